>>> src/wcs_pkg.sv
// wcs_pkg: shared types and constants for the world-to-camera-space transform
// no dependencies; imported by the interfaces, setup sequencer, datapath and top level
package wcs_pkg;

   localparam int COORD_W = 32;
   localparam int QUAT_W  = 18;
   localparam int A_W     = 22;
   localparam int IDX_W   = 3;

   localparam logic signed [QUAT_W-1:0] Q_ONE = 18'sd65536;
   localparam logic signed [QUAT_W-1:0] Q_MAX = 18'sd131071;
   localparam logic signed [QUAT_W-1:0] Q_MIN = 18'sh20000;

   // register indexes of the csr port
   localparam logic [IDX_W-1:0] REG_CAM_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_CAM_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_CAM_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROT_X = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROT_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROT_Z = 3'd5;
   localparam logic [IDX_W-1:0] REG_ROT_W = 3'd6;

   // constant coefficients seen by the datapath
   typedef struct packed {
      logic signed [COORD_W-1:0] cam_x;
      logic signed [COORD_W-1:0] cam_y;
      logic signed [COORD_W-1:0] cam_z;
      logic signed [QUAT_W-1:0]  ux;
      logic signed [QUAT_W-1:0]  uy;
      logic signed [QUAT_W-1:0]  uz;
      logic signed [QUAT_W-1:0]  w;
      logic signed [A_W-1:0]     a;
      logic                      inv_clip;
   } coef_type;

endpackage

>>> src/wcs_if.sv
// wcs_if: valid/ready channel interfaces for vertex requests and results
// depends on wcs_pkg for field widths
interface wcs_req_if import wcs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] world_x;
   logic signed [COORD_W-1:0] world_y;
   logic signed [COORD_W-1:0] world_z;
   modport source(output valid, world_x, world_y, world_z, input ready);
   modport sink(input valid, world_x, world_y, world_z, output ready);
endinterface

interface wcs_rsp_if import wcs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] view_x;
   logic signed [COORD_W-1:0] view_y;
   logic signed [COORD_W-1:0] view_z;
   logic                      clipped;
   modport source(output valid, view_x, view_y, view_z, clipped, input ready);
   modport sink(input valid, view_x, view_y, view_z, clipped, output ready);
endinterface

>>> src/world_to_camera_space.sv
// world_to_camera_space: top level of the quaternion view transform
// depends on wcs_pkg, wcs_if, wcs_setup and wcs_datapath
//
// usage:
//  - req_ch carries one world-space vertex per request (Q16.16), rsp_ch returns
//    the camera-space vertex, saturated to 32 bits, with a clipped flag
//  - csr port: write enable, index 0..6 (cam x/y/z, rot x/y/z/w), 32-bit data;
//    indexes beyond 6 are ignored
//  - a rotation write (re)starts the setup sequencer that derives the inverse
//    quaternion: squares of the components, then a bit-serial divider pass per
//    component, then w^2 - u.u; req_ch.ready stays low from the last rotation
//    write until the sequencer is done
//  - an accepted request passes the difference, products, dot/cross, scale and
//    sum stages in order before rsp_ch.valid rises
//  - throughput: one request per cycle while the setup sequencer is idle and
//    rsp_ch does not stall; the five-stage pipeline advances as a whole
//  - reset: identity rotation and zero camera position, ready right after reset
//  - when rsp_ch.ready is low with a result waiting, the pipeline holds all
//    stages and req_ch.ready drops; nothing is lost or repeated
module world_to_camera_space import wcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [COORD_W-1:0] csr_wdata,
   wcs_req_if.sink            req_ch,
   wcs_rsp_if.source          rsp_ch
);

   coef_type coef;
   logic     setup_idle;
   logic     adv;
   logic     in_fire;

   // coefficient registers and inverse quaternion sequencer
   wcs_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef),
      .idle      (setup_idle)
   );

   // requests only enter while coefficients are settled and the pipe can move
   assign req_ch.ready = adv && setup_idle && !reset;
   assign in_fire      = req_ch.valid && req_ch.ready;

   wcs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_fire   (in_fire),
      .in_x      (req_ch.world_x),
      .in_y      (req_ch.world_y),
      .in_z      (req_ch.world_z),
      .out_ready (rsp_ch.ready),
      .adv       (adv),
      .out_valid (rsp_ch.valid),
      .out_x     (rsp_ch.view_x),
      .out_y     (rsp_ch.view_y),
      .out_z     (rsp_ch.view_z),
      .out_clip  (rsp_ch.clipped)
   );

endmodule

>>> src/wcs_setup.sv
// wcs_setup: csr registers and the sequencer that derives the inverse quaternion
// depends on wcs_pkg; one shared squarer and a bit-serial restoring divider
module wcs_setup import wcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [COORD_W-1:0]       csr_wdata,
   output coef_type                 coef,
   output logic                     idle
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQR  = 6'b000010,
      ST_LOAD = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_ASQ  = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [4:0]                bit_ff, bit_in;
   logic [36:0]               s_ff, s_in;
   logic [56:0]               rem_ff, rem_in;
   logic [18:0]               quot_ff, quot_in;
   logic                      ovf_ff, ovf_in;
   logic signed [37:0]        acc_ff, acc_in;
   logic signed [COORD_W-1:0] cam_ff [3];
   logic signed [QUAT_W-1:0]  rot_ff [4];
   logic signed [QUAT_W-1:0]  inv_ff [4], inv_in [4];
   logic signed [A_W-1:0]     a_ff, a_in;
   logic                      clip_ff, clip_in;

   logic signed [QUAT_W-1:0]  sq_op;
   logic signed [35:0]        sq_prod;
   logic signed [QUAT_W-1:0]  q_cur;
   logic [QUAT_W-1:0]         q_mag;
   logic [56:0]               dsh;
   logic                      neg;
   logic signed [37:0]        a_rnd;

   assign q_cur   = rot_ff[cnt_ff];
   assign q_mag   = q_cur[QUAT_W-1] ? QUAT_W'(-q_cur) : QUAT_W'(q_cur);
   assign sq_op   = (state_ff == ST_ASQ) ? inv_ff[cnt_ff] : q_cur;
   assign sq_prod = 36'(sq_op * sq_op);
   assign dsh     = 57'({s_ff, 1'b0}) << bit_ff;
   // inverse vector part is the negated quaternion, scalar part keeps its sign
   assign neg     = (cnt_ff == 2'd3) ? q_cur[QUAT_W-1]
                                     : (!q_cur[QUAT_W-1] && q_cur != '0);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      ovf_in   = ovf_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      clip_in  = clip_ff;
      a_rnd    = '0;
      for (int i = 0; i < 4; i++) inv_in[i] = inv_ff[i];
      case (state_ff)
         ST_IDLE: ;
         ST_SQR: begin
            s_in   = s_ff + 37'(unsigned'(sq_prod));
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               cnt_in = 2'd0;
               if (s_in == '0) begin
                  // zero quaternion falls back to identity
                  for (int i = 0; i < 3; i++) inv_in[i] = '0;
                  inv_in[3] = Q_ONE;
                  acc_in    = '0;
                  state_in  = ST_ASQ;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            rem_in   = {6'd0, q_mag, 33'd0} + 57'(s_ff);
            bit_in   = 5'd19;
            quot_in  = '0;
            ovf_in   = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= dsh) begin
               rem_in = rem_ff - dsh;
               if (bit_ff == 5'd19) ovf_in = 1'b1;
               else quot_in = quot_ff | (19'd1 << bit_ff);
            end
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!neg) begin
               if (ovf_ff || quot_ff > 19'd131071) begin
                  inv_in[cnt_ff] = Q_MAX;
                  clip_in        = 1'b1;
               end else begin
                  inv_in[cnt_ff] = QUAT_W'(quot_ff);
               end
            end else begin
               if (ovf_ff || quot_ff > 19'd131072) begin
                  inv_in[cnt_ff] = Q_MIN;
                  clip_in        = 1'b1;
               end else begin
                  inv_in[cnt_ff] = QUAT_W'(-quot_ff);
               end
            end
            if (cnt_ff == 2'd3) begin
               cnt_in   = 2'd0;
               acc_in   = '0;
               state_in = ST_ASQ;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_ASQ: begin
            // a = w^2 - u.u, rounded half up to 16 fraction bits
            if (cnt_ff == 2'd3) acc_in = acc_ff + 38'(sq_prod);
            else acc_in = acc_ff - 38'(sq_prod);
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               a_rnd    = acc_in + 38'sd32768;
               a_in     = a_rnd[37:16];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // any rotation write starts the derivation over from the first square
      if (csr_we && (csr_index == REG_ROT_X || csr_index == REG_ROT_Y ||
                     csr_index == REG_ROT_Z || csr_index == REG_ROT_W)) begin
         state_in = ST_SQR;
         cnt_in   = 2'd0;
         s_in     = '0;
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         bit_ff    <= '0;
         ovf_ff    <= 1'b0;
         clip_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cam_ff[i] <= '0;
            rot_ff[i] <= '0;
            inv_ff[i] <= '0;
         end
         rot_ff[3] <= Q_ONE;
         inv_ff[3] <= Q_ONE;
         a_ff      <= A_W'(65536);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         ovf_ff   <= ovf_in;
         clip_ff  <= clip_in;
         a_ff     <= a_in;
         for (int i = 0; i < 4; i++) inv_ff[i] <= inv_in[i];
         if (csr_we) begin
            case (csr_index)
               REG_CAM_X: cam_ff[0] <= csr_wdata;
               REG_CAM_Y: cam_ff[1] <= csr_wdata;
               REG_CAM_Z: cam_ff[2] <= csr_wdata;
               REG_ROT_X: rot_ff[0] <= csr_wdata[QUAT_W-1:0];
               REG_ROT_Y: rot_ff[1] <= csr_wdata[QUAT_W-1:0];
               REG_ROT_Z: rot_ff[2] <= csr_wdata[QUAT_W-1:0];
               REG_ROT_W: rot_ff[3] <= csr_wdata[QUAT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      acc_ff  <= acc_in;
   end

   assign idle           = (state_ff == ST_IDLE);
   assign coef.cam_x     = cam_ff[0];
   assign coef.cam_y     = cam_ff[1];
   assign coef.cam_z     = cam_ff[2];
   assign coef.ux        = inv_ff[0];
   assign coef.uy        = inv_ff[1];
   assign coef.uz        = inv_ff[2];
   assign coef.w         = inv_ff[3];
   assign coef.a         = a_ff;
   assign coef.inv_clip  = clip_ff;

endmodule

>>> src/wcs_datapath.sv
// wcs_datapath: five-stage vertex pipeline, subtract, products, dot/cross, scale, sum
// depends on wcs_pkg for coef_type and widths
module wcs_datapath import wcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  coef_type                  coef,
   input  logic                      in_fire,
   input  logic signed [COORD_W-1:0] in_x,
   input  logic signed [COORD_W-1:0] in_y,
   input  logic signed [COORD_W-1:0] in_z,
   input  logic                      out_ready,
   output logic                      adv,
   output logic                      out_valid,
   output logic signed [COORD_W-1:0] out_x,
   output logic signed [COORD_W-1:0] out_y,
   output logic signed [COORD_W-1:0] out_z,
   output logic                      out_clip
);

   logic [4:0] vld_ff;

   // stage 0: difference
   logic signed [32:0] v_ff [3];
   // stage 1: products
   logic signed [50:0] p_ff [9];
   logic signed [54:0] av1_ff [3];
   // stage 2: rounded dot and cross
   logic signed [36:0] b_ff;
   logic signed [35:0] c_ff [3];
   logic signed [54:0] av2_ff [3];
   // stage 3: scaled terms
   logic signed [55:0] bu_ff [3];
   logic signed [54:0] wc_ff [3];
   logic signed [54:0] av3_ff [3];
   // stage 4: output
   logic signed [COORD_W-1:0] o_ff [3];
   logic                      clip_ff;

   logic signed [52:0] sb;
   logic signed [51:0] sc [3];
   logic signed [57:0] acc [3];
   logic signed [41:0] rs [3];
   logic signed [COORD_W-1:0] o_in [3];
   logic [2:0]                sat;
   logic signed [QUAT_W-1:0]  u [3];

   assign adv = !vld_ff[4] || out_ready;
   assign u[0] = coef.ux;
   assign u[1] = coef.uy;
   assign u[2] = coef.uz;

   assign sb = 53'(p_ff[0]) + 53'(p_ff[1]) + 53'(p_ff[2]) + 53'sd32768;
   // cross terms: (uy vz - uz vy, uz vx - ux vz, ux vy - uy vx)
   assign sc[0] = 52'(p_ff[3]) - 52'(p_ff[4]) + 52'sd32768;
   assign sc[1] = 52'(p_ff[5]) - 52'(p_ff[6]) + 52'sd32768;
   assign sc[2] = 52'(p_ff[7]) - 52'(p_ff[8]) + 52'sd32768;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i]  = 58'(av3_ff[i]) + 58'(bu_ff[i]) + 58'(wc_ff[i]) + 58'sd32768;
         rs[i]   = acc[i][57:16];
         sat[i]  = (rs[i][41:31] != {11{rs[i][31]}});
         if (!sat[i]) o_in[i] = rs[i][31:0];
         else if (rs[i][41]) o_in[i] = 32'sh8000_0000;
         else o_in[i] = 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], in_fire};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[0] <= 33'(in_x) - 33'(coef.cam_x);
         v_ff[1] <= 33'(in_y) - 33'(coef.cam_y);
         v_ff[2] <= 33'(in_z) - 33'(coef.cam_z);

         p_ff[0] <= 51'(coef.ux * v_ff[0]);
         p_ff[1] <= 51'(coef.uy * v_ff[1]);
         p_ff[2] <= 51'(coef.uz * v_ff[2]);
         p_ff[3] <= 51'(coef.uy * v_ff[2]);
         p_ff[4] <= 51'(coef.uz * v_ff[1]);
         p_ff[5] <= 51'(coef.uz * v_ff[0]);
         p_ff[6] <= 51'(coef.ux * v_ff[2]);
         p_ff[7] <= 51'(coef.ux * v_ff[1]);
         p_ff[8] <= 51'(coef.uy * v_ff[0]);
         for (int i = 0; i < 3; i++) av1_ff[i] <= 55'(coef.a * v_ff[i]);

         b_ff <= sb[52:16];
         for (int i = 0; i < 3; i++) begin
            c_ff[i]   <= sc[i][51:16];
            av2_ff[i] <= av1_ff[i];
         end

         for (int i = 0; i < 3; i++) begin
            bu_ff[i]  <= {55'(b_ff * u[i]), 1'b0};
            wc_ff[i]  <= {54'(coef.w * c_ff[i]), 1'b0};
            av3_ff[i] <= av2_ff[i];
         end

         for (int i = 0; i < 3; i++) o_ff[i] <= o_in[i];
         clip_ff <= (|sat) | coef.inv_clip;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
   assign out_clip  = clip_ff;

endmodule
